/* rtl/trmq_pkg.sv */
// Shared types, codes and helper functions of the timed release message queue.
package trmq_pkg;

    // Action codes of an input word.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Status codes of a result word.
    localparam logic STATUS_RELEASED = 1'b0;
    localparam logic STATUS_DROPPED  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] msg_word;
        logic [2:0]  msg_length;
        logic [62:0] time_ns;
    } in_item_t;

    typedef struct packed {
        logic [31:0] packet;
        logic        status;
    } out_item_t;

    // Classified command passed from the front end to the heap engine.
    typedef struct packed {
        logic        is_tick;
        logic [31:0] word;
        logic [62:0] time_ns;
    } cmd_t;

    // One stored heap entry.
    typedef struct packed {
        logic [62:0] time_ns;
        logic [31:0] packet;
        logic [31:0] tag;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_POP_ROOT,
        ST_POP_LAST,
        ST_DN_LEFT,
        ST_DN_LCMP,
        ST_DN_RCMP,
        ST_DN_MOVE
    } heap_state_t;

    // Keeps the valid bytes of a word, least significant first.
    function automatic logic [31:0] pack_word(input logic [31:0] word,
                                              input logic [2:0] len);
        logic [31:0] mask;
        case (len)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
        return word & mask;
    endfunction

    // True when entry a must leave before entry b; ties go to the older tag.
    function automatic logic leaves_first(input entry_t a, input entry_t b,
                                          input logic [31:0] counter);
        logic [31:0] age_a;
        logic [31:0] age_b;
        age_a = counter - a.tag;
        age_b = counter - b.tag;
        if (a.time_ns != b.time_ns) begin
            return a.time_ns < b.time_ns;
        end
        return age_a > age_b;
    endfunction

endpackage

/* rtl/trmq_front.sv */
// Front end: accepts input words, packs the message bytes and queues commands.
module trmq_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  trmq_pkg::in_item_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output trmq_pkg::cmd_t    cmd_data
);
    import trmq_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;
    cmd_t       new_cmd;

    // Classify and pack the incoming word.
    always_comb begin
        new_cmd.is_tick = (s_data.action == ACT_TICK);
        new_cmd.word    = pack_word(s_data.msg_word, s_data.msg_length);
        new_cmd.time_ns = s_data.time_ns;
    end

    assign s_ready   = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd_data  = slot_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Two-entry command queue between front and back.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= new_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* rtl/trmq_heap.sv */
// Back end: binary min-heap in a memory, with sift up and sift down sequencing.
module trmq_heap #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  trmq_pkg::cmd_t     cmd_data,
    output logic               m_valid,
    input  logic               m_ready,
    output trmq_pkg::out_item_t m_data
);
    import trmq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = AW + 2;

    entry_t        mem [QUEUE_DEPTH];
    entry_t        rd_q_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    heap_state_t   state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [31:0]   counter_reg, counter_next;
    logic [AW-1:0] idx_reg, idx_next;
    entry_t        hold_reg, hold_next;
    entry_t        cand_reg, cand_next;
    logic [AW-1:0] cand_idx_reg, cand_idx_next;
    logic          cand_child_reg, cand_child_next;
    logic [62:0]   now_reg, now_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_data_reg, m_data_next;

    logic [LW-1:0] left_idx;
    logic [LW-1:0] right_idx;
    logic [AW-1:0] parent_idx;
    logic [CW-1:0] fill_dec;

    assign left_idx   = {1'b0, idx_reg, 1'b1};
    assign right_idx  = left_idx + LW'(1);
    assign parent_idx = (idx_reg - AW'(1)) >> 1;
    assign fill_dec   = fill_reg - CW'(1);

    assign cmd_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Heap storage with one write port and a registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // State and payload registers.
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        hold_reg       <= hold_next;
        cand_reg       <= cand_next;
        cand_idx_reg   <= cand_idx_next;
        cand_child_reg <= cand_child_next;
        now_reg        <= now_next;
        m_data_reg     <= m_data_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            counter_reg <= counter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Sequencer for push, release, sift up and sift down.
    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        counter_next    = counter_reg;
        idx_next        = idx_reg;
        hold_next       = hold_reg;
        cand_next       = cand_reg;
        cand_idx_next   = cand_idx_reg;
        cand_child_next = cand_child_reg;
        now_next        = now_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = hold_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    now_next = cmd_data.time_ns;
                    if (!cmd_data.is_tick) begin
                        if (fill_reg == CW'(QUEUE_DEPTH)) begin
                            m_valid_next       = 1'b1;
                            m_data_next.packet = cmd_data.word;
                            m_data_next.status = STATUS_DROPPED;
                        end else begin
                            hold_next.time_ns = cmd_data.time_ns;
                            hold_next.packet  = cmd_data.word;
                            hold_next.tag     = counter_reg;
                            counter_next      = counter_reg + 32'd1;
                            fill_next         = fill_reg + CW'(1);
                            idx_next          = AW'(fill_reg);
                            state_next        = ST_UP_CHK;
                        end
                    end else if (fill_reg != '0) begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_POP_ROOT;
                    end
                end
            end
            ST_UP_CHK: begin
                if (idx_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                wr_en = 1'b1;
                if (leaves_first(hold_reg, rd_q_reg, counter_reg)) begin
                    wr_data    = rd_q_reg;
                    idx_next   = parent_idx;
                    state_next = ST_UP_CHK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP_ROOT: begin
                if (rd_q_reg.time_ns > now_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    m_valid_next       = 1'b1;
                    m_data_next.packet = rd_q_reg.packet;
                    m_data_next.status = STATUS_RELEASED;
                    fill_next          = fill_dec;
                    if (fill_dec == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(fill_dec);
                        state_next = ST_POP_LAST;
                    end
                end
            end
            ST_POP_LAST: begin
                hold_next  = rd_q_reg;
                idx_next   = '0;
                state_next = ST_DN_LEFT;
            end
            ST_DN_LEFT: begin
                if (left_idx >= LW'(fill_reg)) begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = left_idx[AW-1:0];
                    state_next = ST_DN_LCMP;
                end
            end
            ST_DN_LCMP: begin
                if (leaves_first(rd_q_reg, hold_reg, counter_reg)) begin
                    cand_next       = rd_q_reg;
                    cand_idx_next   = left_idx[AW-1:0];
                    cand_child_next = 1'b1;
                end else begin
                    cand_next       = hold_reg;
                    cand_child_next = 1'b0;
                end
                if (right_idx < LW'(fill_reg)) begin
                    rd_en      = 1'b1;
                    rd_addr    = right_idx[AW-1:0];
                    state_next = ST_DN_RCMP;
                end else begin
                    state_next = ST_DN_MOVE;
                end
            end
            ST_DN_RCMP: begin
                if (leaves_first(rd_q_reg, cand_reg, counter_reg)) begin
                    cand_next       = rd_q_reg;
                    cand_idx_next   = right_idx[AW-1:0];
                    cand_child_next = 1'b1;
                end
                state_next = ST_DN_MOVE;
            end
            ST_DN_MOVE: begin
                wr_en = 1'b1;
                if (cand_child_reg) begin
                    wr_data    = cand_reg;
                    idx_next   = cand_idx_reg;
                    state_next = ST_DN_LEFT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/timed_release_message_queue_unit.sv */
// Top level: send-time ordered message queue with a front end and a heap engine.
// A push climbs one heap level per ST_UP_CHK and ST_UP_CMP pass; a release is
// registered in ST_POP_ROOT after the root is read, and the sift down then takes
// ST_DN_LEFT to ST_DN_MOVE per level of the heap memory (one read, one write port).
// The heap takes a new word only when idle with no result waiting.
// Reset (aresetn, synchronous, active low) empties the queue and the tag counter.
module timed_release_message_queue_unit #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  trmq_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output trmq_pkg::out_item_t m_data
);
    import trmq_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd_data;

    trmq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data)
    );

    trmq_heap #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_heap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* tb/testbench.sv */
// Testbench of the timed release message queue: directed and random words, checked in order.
`timescale 1ns / 100ps

module testbench;
    import trmq_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int CYCLE_MAX   = 1500000;
    localparam int LONG_CYCLES = 30000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    timed_release_message_queue_unit #(.QUEUE_DEPTH(DEPTH)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Predicted heap contents and tag counter.
    logic [62:0] heap_time [DEPTH];
    logic [31:0] heap_word [DEPTH];
    logic [31:0] heap_tag  [DEPTH];
    int          heap_fill;
    logic [31:0] tag_next = '0;

    in_item_t    pending_words[$];
    out_item_t   expected_results[$];
    int          error_count;
    int          cycle_count;
    int          pushes_sent;
    int          ticks_sent;
    int          releases_seen;
    int          drops_seen;
    bit          long_stall;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] masked_word(logic [31:0] w, logic [2:0] n);
        if (n >= 3'd4) return w;
        return w & ((32'h1 << (8 * n)) - 32'h1);
    endfunction

    function automatic bit goes_first(int a, int b);
        logic [31:0] age_a;
        logic [31:0] age_b;
        age_a = tag_next - heap_tag[a];
        age_b = tag_next - heap_tag[b];
        if (heap_time[a] != heap_time[b]) return heap_time[a] < heap_time[b];
        return age_a > age_b;
    endfunction

    task automatic swap_slots(int a, int b);
        logic [62:0] t;
        logic [31:0] w;
        logic [31:0] g;
        t = heap_time[a]; w = heap_word[a]; g = heap_tag[a];
        heap_time[a] = heap_time[b]; heap_word[a] = heap_word[b]; heap_tag[a] = heap_tag[b];
        heap_time[b] = t; heap_word[b] = w; heap_tag[b] = g;
    endtask

    // Apply one accepted word to the predicted heap, queueing any result.
    task automatic schedule_word(in_item_t it);
        out_item_t r;
        int        i;
        int        l;
        int        best;
        if (it.action == ACT_PUSH) begin
            r.packet = masked_word(it.msg_word, it.msg_length);
            if (heap_fill >= DEPTH) begin
                r.status = STATUS_DROPPED;
                expected_results.push_back(r);
                return;
            end
            i = heap_fill;
            heap_time[i] = it.time_ns;
            heap_word[i] = r.packet;
            heap_tag[i]  = tag_next;
            tag_next++;
            heap_fill++;
            while (i > 0 && goes_first(i, (i - 1) / 2)) begin
                swap_slots(i, (i - 1) / 2);
                i = (i - 1) / 2;
            end
            return;
        end
        if (heap_fill == 0 || heap_time[0] > it.time_ns) return;
        r.packet = heap_word[0];
        r.status = STATUS_RELEASED;
        expected_results.push_back(r);
        heap_fill--;
        if (heap_fill > 0) begin
            heap_time[0] = heap_time[heap_fill];
            heap_word[0] = heap_word[heap_fill];
            heap_tag[0]  = heap_tag[heap_fill];
            i = 0;
            forever begin
                l = 2 * i + 1;
                best = i;
                if (l < heap_fill && goes_first(l, best)) best = l;
                if (l + 1 < heap_fill && goes_first(l + 1, best)) best = l + 1;
                if (best == i) break;
                swap_slots(i, best);
                i = best;
            end
        end
    endtask

    function automatic in_item_t make_word(logic act, logic [62:0] t);
        in_item_t it;
        it.action     = act;
        it.msg_word   = $urandom;
        it.msg_length = 3'($urandom_range(7, 0));
        it.time_ns    = t;
        return it;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_data     <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && s_ready) begin
                schedule_word(s_data);
                if (s_data.action == ACT_PUSH) pushes_sent++;
                else ticks_sent++;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_data  <= pending_words.pop_front();
                s_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: one long hold counted here on request, otherwise calm and busy phases.
    int stall_phase;
    int stall_hold;
    int long_hold;
    bit long_hold_used;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready        <= 1'b0;
            stall_phase    <= 0;
            stall_hold     <= 0;
            long_hold      <= 0;
            long_hold_used <= 1'b0;
        end else if (long_stall && !long_hold_used) begin
            long_hold_used <= 1'b1;
            long_hold      <= LONG_CYCLES;
            m_ready        <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            m_ready   <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            m_ready    <= 1'b0;
        end else begin
            stall_phase <= (stall_phase + 1) % 600;
            if (stall_phase < 200) m_ready <= 1'b1;
            else if ($urandom_range(3, 0) == 0) begin
                m_ready    <= 1'b0;
                stall_hold <= $urandom_range(6, 0);
            end else m_ready <= 1'b1;
        end
    end

    // Monitor: compare each result word with the oldest expectation.
    always @(posedge aclk) begin
        out_item_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result packet=%h status=%b",
                         $time, m_data.packet, m_data.status);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_data.packet !== exp_r.packet) begin
                    $display("%0t: packet mismatch expected %h actual %h",
                             $time, exp_r.packet, m_data.packet);
                    error_count++;
                end
                if (m_data.status !== exp_r.status) begin
                    $display("%0t: status mismatch expected %b actual %b",
                             $time, exp_r.status, m_data.status);
                    error_count++;
                end
                if (m_data.status == STATUS_DROPPED) drops_seen++;
                else releases_seen++;
            end
        end
    end

    // Watchdog on total cycles.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_word(logic act, logic [62:0] t);
        pending_words.push_back(make_word(act, t));
    endtask

    // Wait until the sender has taken everything queued so far.
    task automatic drain_input;
        while (pending_words.size() > 0 || s_valid) @(posedge aclk);
    endtask

    initial begin
        logic [62:0] now_t;
        in_item_t    it;
        int          k;
        aresetn = 1'b0;
        long_stall = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty tick, every length, extreme fields, equal times.
        add_word(ACT_TICK, 63'h7FFF_FFFF_FFFF_FFFF);
        for (k = 0; k < 8; k++) begin
            it = make_word(ACT_PUSH, 63'd100);
            it.msg_word = 32'hFFFF_FFFF;
            it.msg_length = 3'(k);
            pending_words.push_back(it);
        end
        it = make_word(ACT_PUSH, 63'h7FFF_FFFF_FFFF_FFFF);
        it.msg_word = 32'h0;
        pending_words.push_back(it);
        add_word(ACT_PUSH, 63'd0);
        add_word(ACT_TICK, 63'd0);
        add_word(ACT_TICK, 63'd99);
        for (k = 0; k < 9; k++) add_word(ACT_TICK, 63'd100);
        add_word(ACT_TICK, 63'h7FFF_FFFF_FFFF_FFFE);
        add_word(ACT_TICK, 63'h7FFF_FFFF_FFFF_FFFF);
        drain_input();

        // Fill the store past capacity while the receiver holds off.
        long_stall = 1;
        for (k = 0; k < DEPTH + 4; k++)
            add_word(ACT_PUSH, 63'($urandom_range(3000, 0)));
        drain_input();

        // Random: clustered send times so ties, drops and due checks all happen.
        now_t = 63'd0;
        for (k = 0; k < 100; k++) begin
            if ($urandom_range(9, 0) == 0) begin
                add_word(1'($urandom_range(1, 0)), 63'({$urandom, $urandom}));
            end else if ($urandom_range(2, 0) == 0) begin
                add_word(ACT_PUSH, now_t + $urandom_range(40, 0));
            end else begin
                now_t = now_t + $urandom_range(60, 0);
                add_word(ACT_TICK, now_t);
            end
        end
        drain_input();
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Covered %0d pushes and %0d ticks: %0d releases, %0d drops on a full store.",
                 pushes_sent, ticks_sent, releases_seen, drops_seen);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
